>>> rtl/binary_stl_vertex_parser_macros.svh
// assertion macros used by bstl_parse
`ifndef BINARY_STL_VERTEX_PARSER_MACROS_SVH
`define BINARY_STL_VERTEX_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// check on every clock edge once reset is released
`define BSTL_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check on every clock edge, reset included
`define BSTL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define BSTL_ASSERT_CLK(lbl, prop, msg)
`define BSTL_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> rtl/bstl_pkg.sv
`timescale 1ns / 1ps

package bstl_pkg;

  // file layout
  localparam int unsigned HeaderBytes = 80;
  localparam int unsigned PrefixBytes = 84;
  localparam int unsigned NormalBytes = 12;
  localparam int unsigned VertexBytes = 12;
  localparam int unsigned AttribBytes = 2;
  localparam int unsigned RecordBytes = NormalBytes + 3 * VertexBytes + AttribBytes;

  typedef enum logic [1:0] {
    KIND_VERTEX   = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_SMALL    = 2'd2,
    KIND_MISMATCH = 2'd3
  } result_kind_e;

  // one result transaction
  typedef struct packed {
    result_kind_e kind;
    logic [31:0]  x;
    logic [31:0]  y;
    logic [31:0]  z;
    logic [33:0]  num;
  } result_t;

  // registered input byte
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_item_t;

endpackage

>>> rtl/bstl_in_stage.sv
`timescale 1ns / 1ps

module bstl_in_stage
  import bstl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] byte_value_i,
  input  logic       free_i,
  output byte_item_t item_o
);

  logic       vld_q, vld_d;
  logic [7:0] data_q, data_d;
  logic       accept;

  // hold the byte while the parser cannot take it
  assign in_stall_o = vld_q & ~free_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    vld_d  = vld_q;
    data_d = data_q;
    if (accept) begin
      vld_d  = 1'b1;
      data_d = byte_value_i;
    end else if (free_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign item_o.valid = vld_q;
  assign item_o.data  = data_q;

endmodule

>>> rtl/bstl_parse.sv
`timescale 1ns / 1ps
`include "binary_stl_vertex_parser_macros.svh"

module bstl_parse
  import bstl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  byte_item_t  item_i,
  input  logic        free_i,
  output logic        res_vld_o,
  output result_t     res_o
);

  logic [31:0] file_len_q, file_len_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] total_q, total_d;
  logic [5:0]  off_q, off_d;
  logic [95:0] shift_q, shift_d;
  logic [33:0] cnt_q, cnt_d;
  logic        failed_q, failed_d;

  logic        fire;
  logic        last;
  logic        too_short;
  logic [31:0] total_new;
  logic [37:0] expect_len;
  logic        mismatch;
  logic        in_window;
  logic        vtx_end;
  logic [5:0]  off_inc;
  logic [7:0]  b;

  assign fire = item_i.valid & free_i;
  assign b    = item_i.data;

  // end of file and short file tests
  assign last      = ({1'b0, pos_q} + 33'd1) >= {1'b0, file_len_q};
  assign too_short = file_len_q < 32'(PrefixBytes);

  // count byte lands in its little-endian slot
  always_comb begin
    total_new = total_q;
    case (pos_q[1:0])
      2'd0:    total_new[7:0]   = total_q[7:0]   | b;
      2'd1:    total_new[15:8]  = total_q[15:8]  | b;
      2'd2:    total_new[23:16] = total_q[23:16] | b;
      default: total_new[31:24] = total_q[31:24] | b;
    endcase
  end

  // expected length from the triangle count
  assign expect_len = 38'(PrefixBytes) + {6'b0, total_new} * 38'(RecordBytes);
  assign mismatch   = expect_len != {6'b0, file_len_q};

  // position within the record
  assign in_window = (off_q >= 6'(NormalBytes)) &&
                     (off_q < 6'(NormalBytes + 3 * VertexBytes));
  assign vtx_end   = (off_q == 6'(NormalBytes + VertexBytes - 1)) ||
                     (off_q == 6'(NormalBytes + 2 * VertexBytes - 1)) ||
                     (off_q == 6'(NormalBytes + 3 * VertexBytes - 1));
  assign off_inc   = off_q + 6'd1;

  // next state and result
  always_comb begin
    file_len_d = file_len_q;
    pos_d      = pos_q;
    total_d    = total_q;
    off_d      = off_q;
    shift_d    = shift_q;
    cnt_d      = cnt_q;
    failed_d   = failed_q;
    res_vld_o  = 1'b0;
    res_o      = '0;

    if (cfg_we_i) begin
      file_len_d = cfg_data_i;
    end

    if (fire) begin
      if (last && too_short) begin
        res_vld_o  = 1'b1;
        res_o.kind = KIND_SMALL;
      end else begin
        if (pos_q < 32'(HeaderBytes)) begin
          // header bytes are dropped
        end else if (pos_q < 32'(PrefixBytes)) begin
          total_d = total_new;
          if (pos_q == 32'(PrefixBytes - 1) && mismatch) begin
            failed_d   = 1'b1;
            res_vld_o  = 1'b1;
            res_o.kind = KIND_MISMATCH;
          end
        end else if (!failed_q) begin
          if (in_window) begin
            shift_d = {b, shift_q[95:8]};
            if (vtx_end && !last) begin
              res_vld_o  = 1'b1;
              res_o.kind = KIND_VERTEX;
              res_o.x    = shift_d[31:0];
              res_o.y    = shift_d[63:32];
              res_o.z    = shift_d[95:64];
              res_o.num  = cnt_q;
              cnt_d      = cnt_q + 34'd1;
            end
          end
          off_d = (off_inc >= 6'(RecordBytes)) ? 6'd0 : off_inc;
        end

        if (last) begin
          if (!failed_d && !res_vld_o) begin
            res_vld_o  = 1'b1;
            res_o.kind = KIND_DONE;
          end
        end else begin
          pos_d = pos_q + 32'd1;
        end
      end

      // restart for the next file
      if (last) begin
        pos_d    = '0;
        total_d  = '0;
        off_d    = '0;
        shift_d  = '0;
        cnt_d    = '0;
        failed_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_len_q <= '0;
      pos_q      <= '0;
      total_q    <= '0;
      off_q      <= '0;
      shift_q    <= '0;
      cnt_q      <= '0;
      failed_q   <= 1'b0;
    end else begin
      file_len_q <= file_len_d;
      pos_q      <= pos_d;
      total_q    <= total_d;
      off_q      <= off_d;
      shift_q    <= shift_d;
      cnt_q      <= cnt_d;
      failed_q   <= failed_d;
    end
  end

  // a vertex only completes on the last byte of a coordinate triple
  `BSTL_ASSERT_CLK(a_vertex_at_end, (res_vld_o && res_o.kind == KIND_VERTEX) |-> vtx_end, "vertex emitted off a triple boundary")
  // the last byte of a file brings the position back to zero
  `BSTL_ASSERT_CLK(a_restart_pos, (fire && last) |=> (pos_q == 32'd0), "position not cleared after last byte")
  // a failed check only exists past the triangle count
  `BSTL_ASSERT_ALWAYS(a_failed_pos, failed_q |-> (pos_q >= 32'(PrefixBytes)), "failed flag set inside prefix")
  // record offset stays inside one record
  `BSTL_ASSERT_ALWAYS(a_off_range, off_q < 6'(RecordBytes), "record offset out of range")

endmodule

>>> rtl/bstl_out_stage.sv
`timescale 1ns / 1ps

module bstl_out_stage
  import bstl_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_vld_i,
  input  result_t res_i,
  input  logic    out_stall_i,
  output logic    free_o,
  output logic    out_valid_o,
  output result_t res_o
);

  logic    vld_q, vld_d;
  result_t res_q, res_d;

  // register can take a new result when empty or being drained
  assign free_o = ~vld_q | ~out_stall_i;

  always_comb begin
    vld_d = vld_q;
    res_d = res_q;
    if (free_o) begin
      vld_d = res_vld_i;
      if (res_vld_i) begin
        res_d = res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

>>> rtl/binary_stl_vertex_parser.sv
`timescale 1ns / 1ps

// Binary STL vertex parser: takes one file byte per transaction and returns
// vertex coordinates as raw IEEE single bits with a running index, then a
// done, too-small or size-mismatch status per file. It accepts one byte per
// clock unless the output stalls; a result passes through the input register,
// the parse and state update, and the result register. The file length is
// written through the configuration port, which is always ready; the user must
// write it only while no bytes are in flight; the block does not enforce this.
module binary_stl_vertex_parser
  import bstl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] file_length_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [31:0] x_bits_o,
  output logic [31:0] y_bits_o,
  output logic [31:0] z_bits_o,
  output logic [33:0] vertex_number_o
);

  byte_item_t item;
  logic       free;
  logic       res_vld;
  result_t    res;
  result_t    res_q;

  assign cfg_ready_o = 1'b1;

  // input register
  bstl_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .byte_value_i (byte_value_i),
    .free_i       (free),
    .item_o       (item)
  );

  // parser state and per-byte decisions
  bstl_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_data_i (file_length_i),
    .item_i     (item),
    .free_i     (free),
    .res_vld_o  (res_vld),
    .res_o      (res)
  );

  // result register
  bstl_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_vld_i   (res_vld),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .res_o       (res_q)
  );

  assign result_kind_o   = res_q.kind;
  assign x_bits_o        = res_q.x;
  assign y_bits_o        = res_q.y;
  assign z_bits_o        = res_q.z;
  assign vertex_number_o = res_q.num;

endmodule
